// ----- rtl/bcf_pkg.sv -----
// package: operation and status codes, control states and the result word type
package bcf_pkg;

    localparam logic [2:0] FUNC_SEND   = 3'd0;
    localparam logic [2:0] FUNC_RECV   = 3'd1;
    localparam logic [2:0] FUNC_CLOSE  = 3'd2;
    localparam logic [2:0] FUNC_ATTACH = 3'd3;
    localparam logic [2:0] FUNC_DETACH = 3'd4;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_RETRY  = 2'd1;
    localparam logic [1:0] STAT_CLOSED = 2'd2;
    localparam logic [1:0] STAT_LIMIT  = 2'd3;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef enum logic
    {
        FSM_IDLE,
        FSM_FETCH
    } fsm_t;

    typedef struct packed
    {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        now_closed;
        logic [4:0]  fill_level;
        logic [7:0]  sender_total;
    } result_t;

endpackage

// ----- rtl/bounded_channel_fifo_core.sv -----
// top level: bounded fifo channel with close, sender tracking and capacity register
//
// input channel (in_valid / in_stall) takes one operation word: func and send_value.
// output channel (out_valid / out_stall) returns one result word per operation:
// status, read_value, now_closed, fill_level and sender_total.
// capacity is written through its own valid/ready port; ready is always high and
// writes are expected only while no operation is in flight.
// result: a receive that finds data goes through FETCH for the slot memory read
// before its result is registered; every other operation registers its result on accept.
// throughput: one operation in flight at a time, so one word per cycle for every
// operation but a receive with data while the receiver does not stall; a receive
// with data holds off new words in FETCH until the slot memory read is back.
// reset clears pointers, fill count, closed flag and sender count, and sets
// capacity to 16; slot contents are not cleared.
// while the receiver stalls, the result is held and in_stall stays high.
module bounded_channel_fifo_core #(
    parameter int DEPTH       = 16,
    parameter int DATA_WIDTH  = 32,
    parameter int MAX_SENDERS = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        capacity_valid,
    output logic        capacity_ready,
    input  logic [4:0]  capacity,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] send_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] read_value,
    output logic        now_closed,
    output logic [4:0]  fill_level,
    output logic [7:0]  sender_total
);

    import bcf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH+1);

    logic [4:0]            capacity_reg;
    logic [FW-1:0]         cap_eff;
    result_t               result;
    logic                  mem_wr_en;
    logic [PW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [PW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    assign capacity_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (capacity_valid && capacity_ready)
        begin
            capacity_reg <= capacity;
        end
    end

    // zero acts as one, anything above the depth acts as the depth
    always_comb
    begin
        if (capacity_reg == 5'd0)
        begin
            cap_eff = {{(FW-1){1'b0}}, 1'b1};
        end
        else if (32'(capacity_reg) > 32'(DEPTH))
        begin
            cap_eff = FW'(DEPTH);
        end
        else
        begin
            cap_eff = FW'(capacity_reg);
        end
    end

    bcf_ctrl #(
        .DEPTH       (DEPTH),
        .DATA_WIDTH  (DATA_WIDTH),
        .MAX_SENDERS (MAX_SENDERS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cap         (cap_eff),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .send_value  (send_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    bcf_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign status       = result.status;
    assign read_value   = result.read_value;
    assign now_closed   = result.now_closed;
    assign fill_level   = result.fill_level;
    assign sender_total = result.sender_total;

endmodule

// ----- rtl/bcf_ram.sv -----
// slot memory: one write port, one read port with registered read data
module bcf_ram #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bcf_ctrl.sv -----
// channel control: pointers, counts, closed flag, memory sequencing and result register
module bcf_ctrl #(
    parameter int DEPTH       = 16,
    parameter int DATA_WIDTH  = 32,
    parameter int MAX_SENDERS = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [$clog2(DEPTH+1)-1:0] cap,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 func,
    input  logic [31:0]                send_value,
    output logic                       out_valid,
    input  logic                       out_stall,
    output bcf_pkg::result_t           result,
    output logic                       mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
    output logic [DATA_WIDTH-1:0]      mem_wr_data,
    output logic                       mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
    input  logic [DATA_WIDTH-1:0]      mem_rd_data
);

    import bcf_pkg::*;

    localparam int PW  = $clog2(DEPTH);
    localparam int FW  = $clog2(DEPTH+1);
    localparam int SCW = $clog2(MAX_SENDERS+1);

    fsm_t             state_reg, state_next;
    logic [PW-1:0]    read_pos_reg, read_pos_next;
    logic [PW-1:0]    write_pos_reg, write_pos_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic             closed_reg, closed_next;
    logic [SCW-1:0]   senders_reg, senders_next;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg;
    logic             load_res;
    logic [1:0]       status_w;

    logic             accept;
    logic [PW:0]      cap_ext;
    logic [PW:0]      wp_inc;
    logic [PW:0]      rp_inc;
    logic [PW-1:0]    wp_adv;
    logic [PW-1:0]    rp_adv;

    assign in_stall = (state_reg == FSM_FETCH) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // a pointer wraps once its next value reaches the capacity
    assign cap_ext = (PW+1)'(cap);
    assign wp_inc  = {1'b0, write_pos_reg} + {{PW{1'b0}}, 1'b1};
    assign rp_inc  = {1'b0, read_pos_reg} + {{PW{1'b0}}, 1'b1};
    assign wp_adv  = (wp_inc >= cap_ext) ? '0 : wp_inc[PW-1:0];
    assign rp_adv  = (rp_inc >= cap_ext) ? '0 : rp_inc[PW-1:0];

    assign mem_wr_addr = write_pos_reg;
    assign mem_wr_data = DATA_WIDTH'(send_value);
    assign mem_rd_addr = read_pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        read_pos_next  = read_pos_reg;
        write_pos_next = write_pos_reg;
        fill_next      = fill_reg;
        closed_next    = closed_reg;
        senders_next   = senders_reg;
        status_w       = STAT_OK;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        load_res       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    load_res       = 1'b1;
                    out_valid_next = 1'b1;
                    case (func)
                        FUNC_SEND:
                        begin
                            if (closed_reg)
                            begin
                                status_w = STAT_CLOSED;
                            end
                            else if (fill_reg >= cap)
                            begin
                                status_w = STAT_RETRY;
                            end
                            else
                            begin
                                mem_wr_en      = 1'b1;
                                write_pos_next = wp_adv;
                                fill_next      = fill_reg + {{(FW-1){1'b0}}, 1'b1};
                            end
                        end
                        FUNC_RECV:
                        begin
                            if (fill_reg != '0)
                            begin
                                // word comes back from memory next cycle
                                mem_rd_en      = 1'b1;
                                read_pos_next  = rp_adv;
                                fill_next      = fill_reg - {{(FW-1){1'b0}}, 1'b1};
                                out_valid_next = 1'b0;
                                state_next     = FSM_FETCH;
                            end
                            else
                            begin
                                status_w = closed_reg ? STAT_CLOSED : STAT_RETRY;
                            end
                        end
                        FUNC_CLOSE:
                        begin
                            closed_next = 1'b1;
                        end
                        FUNC_ATTACH:
                        begin
                            if (senders_reg >= SCW'(MAX_SENDERS))
                            begin
                                status_w = STAT_LIMIT;
                            end
                            else
                            begin
                                senders_next = senders_reg + {{(SCW-1){1'b0}}, 1'b1};
                            end
                        end
                        FUNC_DETACH:
                        begin
                            if (senders_reg == '0)
                            begin
                                status_w = STAT_LIMIT;
                            end
                            else
                            begin
                                senders_next = senders_reg - {{(SCW-1){1'b0}}, 1'b1};
                                // last sender gone closes the channel
                                if (senders_reg == {{(SCW-1){1'b0}}, 1'b1})
                                begin
                                    closed_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            status_w = STAT_OK;
                        end
                    endcase
                end
            end
            FSM_FETCH:
            begin
                out_valid_next = 1'b1;
                state_next     = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            read_pos_reg  <= '0;
            write_pos_reg <= '0;
            fill_reg      <= '0;
            closed_reg    <= 1'b0;
            senders_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            read_pos_reg  <= read_pos_next;
            write_pos_reg <= write_pos_next;
            fill_reg      <= fill_next;
            closed_reg    <= closed_next;
            senders_reg   <= senders_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg.status       <= status_w;
            res_reg.read_value   <= '0;
            res_reg.now_closed   <= closed_next;
            res_reg.fill_level   <= 5'(fill_next);
            res_reg.sender_total <= 8'(senders_next);
        end
        else if (state_reg == FSM_FETCH)
        begin
            res_reg.read_value <= 32'(mem_rd_data);
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

// ----- test/bcf_checker.sv -----
// checker: watches the fifo channel ports, predicts each result word and compares it
`timescale 1ns / 1ps

module bcf_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        capacity_valid,
    input  logic        capacity_ready,
    input  logic [4:0]  capacity,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] send_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [31:0] read_value,
    input  logic        now_closed,
    input  logic [4:0]  fill_level,
    input  logic [7:0]  sender_total,
    output int          failures,
    output int          pending
);

    import bcf_pkg::*;

    localparam int SLOT_COUNT  = 16;
    localparam int SENDER_CAP  = 255;

    logic [31:0] slot_mem [SLOT_COUNT];
    int          rd_ptr;
    int          wr_ptr;
    int          level;
    logic        closed;
    int          senders;
    logic [4:0]  cap_reg;
    int          fail_cnt = 0;
    result_t     pending_replies [$];

    function automatic int wrap_next(input int pos, input int lim);
        return (pos + 1 >= lim) ? 0 : pos + 1;
    endfunction

    function automatic result_t predict_channel_op(input logic [2:0] op, input logic [31:0] word);
        result_t r;
        int      lim;
        lim = (cap_reg == 5'd0) ? 1 : ((int'(cap_reg) > SLOT_COUNT) ? SLOT_COUNT : int'(cap_reg));
        r = '0;
        r.status = STAT_OK;
        case (op)
            FUNC_SEND:
            begin
                if (closed)
                    r.status = STAT_CLOSED;
                else if (level >= lim)
                    r.status = STAT_RETRY;
                else
                begin
                    slot_mem[wr_ptr] = word;
                    wr_ptr = wrap_next(wr_ptr, lim);
                    level++;
                end
            end
            FUNC_RECV:
            begin
                if (level > 0)
                begin
                    r.read_value = slot_mem[rd_ptr];
                    rd_ptr = wrap_next(rd_ptr, lim);
                    level--;
                end
                else
                    r.status = closed ? STAT_CLOSED : STAT_RETRY;
            end
            FUNC_CLOSE:
                closed = 1'b1;
            FUNC_ATTACH:
            begin
                if (senders >= SENDER_CAP)
                    r.status = STAT_LIMIT;
                else
                    senders++;
            end
            FUNC_DETACH:
            begin
                if (senders == 0)
                    r.status = STAT_LIMIT;
                else
                begin
                    senders--;
                    // losing the last sender closes the channel
                    if (senders == 0)
                        closed = 1'b1;
                end
            end
            default:
                ;
        endcase
        r.now_closed   = closed;
        r.fill_level   = 5'(level);
        r.sender_total = 8'(senders);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_mem[i] = '0;
            rd_ptr  = 0;
            wr_ptr  = 0;
            level   = 0;
            closed  = 1'b0;
            senders = 0;
            cap_reg = CAPACITY_RESET;
            pending_replies.delete();
            pending <= 0;
            failures <= fail_cnt;
        end
        else
        begin
            if (capacity_valid && capacity_ready)
                cap_reg = capacity;
            // retire the result word before queuing a new one, the block never answers in the cycle it accepts
            if (out_valid && !out_stall)
            begin
                got.status       = status;
                got.read_value   = read_value;
                got.now_closed   = now_closed;
                got.fill_level   = fill_level;
                got.sender_total = sender_total;
                if (pending_replies.size() == 0)
                begin
                    $display("%0t ns: unexpected result word: expected none, got 0x%0h",
                             $time, got);
                    fail_cnt++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("now_closed", 32'(want.now_closed), 32'(got.now_closed));
                    check_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
                    check_field("sender_total", 32'(want.sender_total), 32'(got.sender_total));
                end
            end
            if (in_valid && !in_stall)
                pending_replies.push_back(predict_channel_op(func, send_value));
            pending  <= pending_replies.size();
            failures <= fail_cnt;
        end
    end

endmodule

// ----- test/tb_bounded_channel_fifo_core.sv -----
// testbench top: drives operation words and capacity writes into the fifo channel core
`timescale 1ns / 1ps

module tb_bounded_channel_fifo_core;
    import bcf_pkg::*;

    localparam logic [2:0] FUNC_NONE_LO = 3'd5;
    localparam logic [2:0] FUNC_NONE_HI = 3'd7;
    localparam int         SLOT_COUNT   = 16;
    localparam int         SENDER_CAP   = 255;
    localparam int         HOLD_CYCLES  = 80;

    typedef enum int
    {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic        clk;
    logic        rst_n;
    logic        capacity_valid;
    logic        capacity_ready;
    logic [4:0]  capacity;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  func;
    logic [31:0] send_value;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        now_closed;
    logic [4:0]  fill_level;
    logic [7:0]  sender_total;

    int failures;
    int pending;
    int hold_ask;
    int senders;
    int burst_left;
    int gap_max;

    bounded_channel_fifo_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_valid (capacity_valid),
        .capacity_ready (capacity_ready),
        .capacity       (capacity),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .send_value     (send_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .now_closed     (now_closed),
        .fill_level     (fill_level),
        .sender_total   (sender_total)
    );

    bcf_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .capacity_valid (capacity_valid),
        .capacity_ready (capacity_ready),
        .capacity       (capacity),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .send_value     (send_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .read_value     (read_value),
        .now_closed     (now_closed),
        .fill_level     (fill_level),
        .sender_total   (sender_total),
        .failures       (failures),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver side: stall pattern changes every stretch, long hold on request
    initial
    begin
        stall_mode_t mode;
        int          left;
        int          period;
        int          hold_seen;
        out_stall <= 1'b0;
        mode = STALL_NONE;
        left = 0;
        period = 2;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_ask != hold_seen)
            begin
                hold_seen = hold_ask;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode   = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
                    left   = $urandom_range(10, 150);
                    period = $urandom_range(2, 5);
                end
                left--;
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 6);
                    default:      out_stall <= (left % period == 0);
                endcase
            end
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // offer one operation word, hold it until taken, then maybe close the burst
    task automatic issue(input logic [2:0] op, input logic [31:0] word);
        int gap;
        in_valid   <= 1'b1;
        func       <= op;
        send_value <= word;
        do @(posedge clk); while (in_stall);
        if (op == FUNC_ATTACH && senders < SENDER_CAP)
            senders++;
        if (op == FUNC_DETACH && senders > 0)
            senders--;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_capacity(input logic [4:0] cap);
        capacity_valid <= 1'b1;
        capacity       <= cap;
        do @(posedge clk); while (!capacity_ready);
        capacity_valid <= 1'b0;
    endtask

    // empty the fifo so both pointers meet before capacity moves
    task automatic drain();
        repeat (SLOT_COUNT + 1) issue(FUNC_RECV, rand_word());
        wait_idle();
    endtask

    task automatic run_mix(input int n, input int pause_at);
        int seg_left;
        int send_pct;
        int r;
        seg_left = 0;
        send_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_idle();
            // switch at random between fill-heavy, drain-heavy and balanced stretches to hit full and empty
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0:       send_pct = 80;
                    1:       send_pct = 25;
                    default: send_pct = 55;
                endcase
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < 5)
                issue(FUNC_ATTACH, rand_word());
            else if (r < 10)
                issue((senders > 1) ? FUNC_DETACH : FUNC_ATTACH, rand_word());
            else if (r < 13)
                issue(3'($urandom_range(FUNC_NONE_LO, FUNC_NONE_HI)), rand_word());
            else if ($urandom_range(0, 99) < send_pct)
                issue(FUNC_SEND, rand_word());
            else
                issue(FUNC_RECV, rand_word());
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        func           <= FUNC_SEND;
        send_value     <= '0;
        capacity_valid <= 1'b0;
        capacity       <= CAPACITY_RESET;
        hold_ask       <= 0;
        senders    = 0;
        burst_left = 1;
        gap_max    = 2;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // detach with nobody attached, receive on empty open channel, spare codes
        issue(FUNC_DETACH, rand_word());
        issue(FUNC_RECV, rand_word());
        for (int k = FUNC_NONE_LO; k <= FUNC_NONE_HI; k++)
            issue(3'(k), rand_word());
        issue(FUNC_ATTACH, rand_word());
        issue(FUNC_ATTACH, rand_word());
        issue(FUNC_SEND, 32'h0000_0000);
        issue(FUNC_SEND, 32'hFFFF_FFFF);
        issue(FUNC_SEND, 32'hAAAA_AAAA);
        issue(FUNC_SEND, 32'h5555_5555);
        repeat (4) issue(FUNC_RECV, rand_word());

        // zero capacity acts as one slot: second send is refused as full
        wait_idle();
        set_capacity(5'd0);
        issue(FUNC_SEND, rand_word());
        issue(FUNC_SEND, rand_word());
        issue(FUNC_RECV, rand_word());

        // grow capacity while words are queued, no wrap yet
        wait_idle();
        set_capacity(5'd4);
        issue(FUNC_SEND, rand_word());
        issue(FUNC_SEND, rand_word());
        wait_idle();
        set_capacity(CAPACITY_RESET);
        issue(FUNC_SEND, rand_word());
        repeat (3) issue(FUNC_RECV, rand_word());

        // sender count up to its limit and past it, then back down
        gap_max = 1;
        while (senders < SENDER_CAP)
            issue(FUNC_ATTACH, rand_word());
        repeat (3) issue(FUNC_ATTACH, rand_word());
        while (senders > 3)
            issue(FUNC_DETACH, rand_word());

        drain();
        set_capacity(5'd31);
        gap_max = 3;
        run_mix(100, -1);

        drain();
        set_capacity(5'd1);
        gap_max = 0;
        run_mix(100, 50);

        drain();
        set_capacity(5'($urandom_range(2, 15)));
        gap_max = 0;
        hold_ask <= hold_ask + 1;
        run_mix(100, -1);

        drain();
        set_capacity(5'($urandom_range(17, 30)));
        gap_max = 6;
        run_mix(100, -1);

        drain();
        set_capacity(CAPACITY_RESET);
        gap_max = 3;
        run_mix(100, 40);

        // fill a small channel, then close it by command or by losing every sender
        drain();
        set_capacity(5'd3);
        repeat (4) issue(FUNC_SEND, rand_word());
        if ($urandom_range(0, 1) == 1)
            issue(FUNC_CLOSE, rand_word());
        else
            while (senders > 0)
                issue(FUNC_DETACH, rand_word());
        issue(FUNC_SEND, rand_word());
        issue(FUNC_CLOSE, rand_word());
        issue(FUNC_ATTACH, rand_word());
        repeat (4) issue(FUNC_RECV, rand_word());
        while (senders > 0)
            issue(FUNC_DETACH, rand_word());
        issue(FUNC_DETACH, rand_word());
        run_mix(30, -1);

        wait_idle();
        repeat (4) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
